/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lruc_pkg.sv */
// ----------------------------------------------------------------------------
// lruc_pkg
// Widths, codes and default sizes for the LRU set-associative cache model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lruc_pkg;

    localparam int ADDR_W     = 64;
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SET_BITS_W = 3;
    localparam int WAYS_W     = 4;
    localparam int OFFSET_W   = 6;
    localparam int OUT_DATA_W = 104;

    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_STAMP_WIDTH  = 32;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STORE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd2;

endpackage

/* rtl/lru_set_assoc_cache_model.sv */
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_model
// Set-associative cache model with least-recently-used replacement and
// saturating hit, miss and eviction totals.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  tdata address, tuser mode
// m_*       out        m_tvalid / m_tready  tdata hit, evicted, counts; tlast
// cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load or store reads the set row from the memory when it is accepted, then
// compares, picks the victim and writes the row back once the output is free.
// A modify accesses its set twice; its second access works on the forwarded row.
// An item of the unused mode is taken without a lookup and gives no result.
// Reset clears one valid flag per set row, so no clearing pass is needed.
// A result waits in the output register; the next lookup holds while it does.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_set_assoc_cache_model
    import lruc_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int STAMP_WIDTH  = DEF_STAMP_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [ADDR_W-1:0]     s_tdata,    // [63:0] address
    input  logic [MODE_W-1:0]     s_tuser,    // [1:0] mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] hit, [1] evicted, [33:2] hit_count, [65:34] miss_count,
    // [97:66] eviction_count, [103:98] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SET_IW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_SETS  = 1 << MAX_SET_BITS;
    localparam int WAY_IW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W    = ($clog2(MAX_WAYS + 1) > WAYS_W) ? $clog2(MAX_WAYS + 1) : WAYS_W;
    localparam int TAG_OFF   = MAX_WAYS;
    localparam int STAMP_OFF = MAX_WAYS * (1 + ADDR_W);
    localparam int ROW_W     = MAX_WAYS * (1 + ADDR_W + STAMP_WIDTH);
    localparam int SHIFT_W   = OFFSET_W + 1;
    localparam int PAD_W     = OUT_DATA_W - 2 - 3 * COUNT_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    logic                   state_reg;
    logic                   second_reg;
    logic                   fwd_sel_reg;
    logic [ADDR_W-1:0]      tag_reg;
    logic [SET_IW-1:0]      set_reg;
    logic [STAMP_WIDTH-1:0] clock_reg;
    logic [COUNT_W-1:0]     hits_reg;
    logic [COUNT_W-1:0]     misses_reg;
    logic [COUNT_W-1:0]     evicts_reg;
    logic [SET_BITS_W-1:0]  set_bits_reg;
    logic [WAYS_W-1:0]      ways_reg;
    logic [OFFSET_W-1:0]    offset_reg;
    logic                   m_tvalid_reg;
    logic                   out_hit_reg;
    logic                   out_evict_reg;
    logic                   out_last_reg;
    logic [NUM_SETS-1:0]    row_ok_reg;
    logic [ROW_W-1:0]       rd_row_reg;
    logic                   rd_ok_reg;
    logic [ROW_W-1:0]       fwd_row_reg;

    logic [ROW_W-1:0]       mem [NUM_SETS];

    logic                   in_accept;
    logic                   rd_en;
    logic                   do_step;
    logic                   out_free;
    logic [SET_BITS_W-1:0]  sbits_eff;
    logic [WCNT_W-1:0]      ways_eff;
    logic [SHIFT_W-1:0]     tag_shift;
    logic [ADDR_W-1:0]      in_tag;
    logic [ADDR_W-1:0]      set_full;
    logic [SET_IW-1:0]      in_set;
    logic [ROW_W-1:0]       cur_row;
    logic [ROW_W-1:0]       wr_row;
    logic                   hit_found;
    logic [WAY_IW-1:0]      hit_way;
    logic [WAY_IW-1:0]      victim;
    logic [STAMP_WIDTH-1:0] best;
    logic [WAY_IW-1:0]      sel_way;
    logic [MAX_WAYS-1:0]    way_valid;
    logic                   evict;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = {{PAD_W{1'b0}}, evicts_reg, misses_reg, hits_reg,
                        out_evict_reg, out_hit_reg};

    assign in_accept = s_tvalid && s_tready;
    assign rd_en     = in_accept && (s_tuser != MODE_NONE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign do_step   = (state_reg == ST_LOOK) && out_free;

    always_comb
    begin
        if (int'(set_bits_reg) > MAX_SET_BITS)
        begin
            sbits_eff = SET_BITS_W'(MAX_SET_BITS);
        end
        else
        begin
            sbits_eff = set_bits_reg;
        end
        if (ways_reg == '0)
        begin
            ways_eff = WCNT_W'(1);
        end
        else if (int'(ways_reg) > MAX_WAYS)
        begin
            ways_eff = WCNT_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WCNT_W'(ways_reg);
        end
    end

    always_comb
    begin
        tag_shift = {1'b0, offset_reg} + SHIFT_W'(sbits_eff);
        if (tag_shift >= SHIFT_W'(ADDR_W))
        begin
            in_tag = '0;
        end
        else
        begin
            in_tag = s_tdata >> tag_shift;
        end
        set_full = s_tdata >> offset_reg;
        for (int i = 0; i < SET_IW; i++)
        begin
            in_set[i] = set_full[i] && (i < int'(sbits_eff));
        end
    end

    always_comb
    begin
        if (fwd_sel_reg)
        begin
            cur_row = fwd_row_reg;
        end
        else if (rd_ok_reg)
        begin
            cur_row = rd_row_reg;
        end
        else
        begin
            cur_row = '0;
        end
    end

    always_comb
    begin
        hit_found = 1'b0;
        hit_way   = '0;
        best      = '1;
        victim    = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (w < int'(ways_eff))
            begin
                if (!hit_found && cur_row[w] &&
                    (cur_row[TAG_OFF + w * ADDR_W +: ADDR_W] == tag_reg))
                begin
                    hit_found = 1'b1;
                    hit_way   = WAY_IW'(w);
                end
                if (cur_row[STAMP_OFF + w * STAMP_WIDTH +: STAMP_WIDTH] < best)
                begin
                    best   = cur_row[STAMP_OFF + w * STAMP_WIDTH +: STAMP_WIDTH];
                    victim = WAY_IW'(w);
                end
            end
        end
    end

    always_comb
    begin
        sel_way   = hit_found ? hit_way : victim;
        way_valid = cur_row[MAX_WAYS-1:0];
        evict     = !hit_found && way_valid[victim];
        wr_row    = cur_row;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (w == int'(sel_way))
            begin
                wr_row[STAMP_OFF + w * STAMP_WIDTH +: STAMP_WIDTH] = clock_reg;
                if (!hit_found)
                begin
                    wr_row[w]                            = 1'b1;
                    wr_row[TAG_OFF + w * ADDR_W +: ADDR_W] = tag_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg <= mem[in_set];
            rd_ok_reg  <= row_ok_reg[in_set];
        end
        if (do_step)
        begin
            mem[set_reg] <= wr_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            tag_reg <= in_tag;
            set_reg <= in_set;
        end
        if (do_step)
        begin
            out_hit_reg   <= hit_found;
            out_evict_reg <= evict;
            out_last_reg  <= !second_reg;
            fwd_row_reg   <= wr_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= '0;
            ways_reg     <= WAYS_W'(1);
            offset_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SET_BITS: set_bits_reg <= cfg_data[SET_BITS_W-1:0];
                CFG_WAYS:     ways_reg     <= cfg_data[WAYS_W-1:0];
                CFG_OFFSET:   offset_reg   <= cfg_data[OFFSET_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            second_reg   <= 1'b0;
            fwd_sel_reg  <= 1'b0;
            clock_reg    <= '0;
            hits_reg     <= '0;
            misses_reg   <= '0;
            evicts_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            row_ok_reg   <= '0;
        end
        else
        begin
            if (do_step)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (rd_en)
            begin
                state_reg   <= ST_LOOK;
                second_reg  <= (s_tuser == MODE_MODIFY);
                fwd_sel_reg <= 1'b0;
            end
            else if (do_step)
            begin
                row_ok_reg[set_reg] <= 1'b1;
                clock_reg           <= clock_reg + 1'b1;
                if (hit_found)
                begin
                    hits_reg <= (hits_reg == '1) ? hits_reg : hits_reg + 1'b1;
                end
                else
                begin
                    misses_reg <= (misses_reg == '1) ? misses_reg : misses_reg + 1'b1;
                end
                if (evict)
                begin
                    evicts_reg <= (evicts_reg == '1) ? evicts_reg : evicts_reg + 1'b1;
                end
                if (second_reg)
                begin
                    second_reg  <= 1'b0;
                    fwd_sel_reg <= 1'b1;
                end
                else
                begin
                    state_reg   <= ST_IDLE;
                    fwd_sel_reg <= 1'b0;
                end
            end
        end
    end

endmodule

/* rtl/lruc_checker.sv */
// ----------------------------------------------------------------------------
// lruc_checker
// Port-level assertions for the LRU set-associative cache model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lruc_checker
    import lruc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [MODE_W-1:0]     s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    // A stalled result keeps its payload.
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // An access keeps the input closed while its set is looked up.
    `ASSERT_NEXT(a_busy_after_access, s_tvalid && s_tready && (s_tuser != MODE_NONE), !s_tready, "input open during lookup")

    // An item of the unused mode leaves the input open.
    `ASSERT_NEXT(a_idle_after_none, s_tvalid && s_tready && (s_tuser == MODE_NONE), s_tready, "unused mode blocked input")

    // While the first result of a modify is shown, its second access is pending.
    `ASSERT_SAME(a_pending_second, m_tvalid && !m_tlast, !s_tready, "input open before second access")

endmodule

bind lru_set_assoc_cache_model lruc_checker u_lruc_checker (.*);
